// File: rtl/hgm_pkg.sv
// ----------------------------------------------------------------------------
// hgm_pkg
// Shared types, register indexes and an arithmetic helper for the height
// gradient moments block.
// ----------------------------------------------------------------------------
package hgm_pkg;

    // payload types
    typedef logic signed [15:0] height_t;
    typedef logic signed [23:0] slope_t;
    typedef logic        [46:0] slope_sq_t;
    typedef logic signed [47:0] slope_uv_t;

    // configuration port types
    typedef logic [1:0]  cfg_index_t;
    typedef logic [15:0] cfg_data_t;
    typedef logic [10:0] dim_cfg_t;
    typedef logic [15:0] gain_t;

    // scaled difference: 17-bit difference times 17-bit signed gain
    typedef logic signed [16:0] diff_t;
    typedef logic signed [33:0] scale_prod_t;

    // register indexes
    localparam cfg_index_t REG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_index_t REG_SCALE_GAIN   = 2'd2;

    // register reset values
    localparam dim_cfg_t IMAGE_WIDTH_RST  = 11'd1024;
    localparam dim_cfg_t IMAGE_HEIGHT_RST = 11'd1024;
    localparam gain_t    SCALE_GAIN_RST   = 16'd256;

    // default size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // smallest usable dimension
    localparam int MIN_DIM = 3;

    // round half up, then divide by 512 (half of Q8.8)
    localparam logic signed [34:0] ROUND_BIAS = 35'sd256;
    localparam logic signed [25:0] SLOPE_MAX  = 26'sd8388607;
    localparam logic signed [25:0] SLOPE_MIN  = -26'sd8388608;

    // round, shift down by nine bits and saturate to the slope range
    function automatic slope_t scale_round_sat(input scale_prod_t prod);
        logic signed [34:0] biased;
        logic signed [25:0] quot;
        biased = {prod[33], prod} + ROUND_BIAS;
        quot   = biased[34:9];
        if (quot > SLOPE_MAX) begin
            return SLOPE_MAX[23:0];
        end
        else if (quot < SLOPE_MIN) begin
            return SLOPE_MIN[23:0];
        end
        else begin
            return quot[23:0];
        end
    endfunction

endpackage

// File: rtl/hgm_in_if.sv
// ----------------------------------------------------------------------------
// hgm_in_if
// Height sample request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hgm_in_if;
    import hgm_pkg::*;

    logic    valid;
    logic    ready;
    height_t height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

// File: rtl/hgm_out_if.sv
// ----------------------------------------------------------------------------
// hgm_out_if
// Slope moment result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hgm_out_if;
    import hgm_pkg::*;

    logic      valid;
    logic      ready;
    slope_t    slope_u;
    slope_t    slope_v;
    slope_sq_t slope_u_sq;
    slope_sq_t slope_v_sq;
    slope_uv_t slope_uv;
    logic      frame_last;

    modport source (
        output valid, output slope_u, output slope_v, output slope_u_sq,
        output slope_v_sq, output slope_uv, output frame_last, input ready
    );
    modport sink (
        input valid, input slope_u, input slope_v, input slope_u_sq,
        input slope_v_sq, input slope_uv, input frame_last, output ready
    );
endinterface

// File: rtl/hgm_cfg_if.sv
// ----------------------------------------------------------------------------
// hgm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hgm_cfg_if;
    import hgm_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/hgm_ram.sv
// ----------------------------------------------------------------------------
// hgm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module hgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/height_gradient_moments.sv
// ----------------------------------------------------------------------------
// height_gradient_moments
// Central difference slope moments of a raster height map, using two line
// buffers held in one RAM.
// ----------------------------------------------------------------------------
//  channel      dir  handshake        payload
//  cfg          in   valid / ready    index, data (register write)
//  height_in    in   valid / ready    height_sample
//  moments_out  out  valid / ready    slope_u, slope_v, slope_u_sq,
//                                     slope_v_sq, slope_uv, frame_last
//
//  A request steps through read, scale, saturate, square and emit states before
//  ready returns; in the last row a further emit step gives the border result
//  of its own texel. The sequence is set by the single RAM read port (three
//  reads per texel) and the shared scale and square multipliers, each used
//  several times. A full output register stalls the sequencer in its emit
//  steps only; the next request is taken while a result still waits downstream.
//  rst_n clears counters, sequencer, config registers and output valid; the line
//  buffers are not cleared, no clearing pass runs. cfg is always ready.
// ----------------------------------------------------------------------------
module height_gradient_moments #(
    parameter int MAX_WIDTH  = hgm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hgm_pkg::MAX_HEIGHT_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    hgm_cfg_if.sink    cfg,
    hgm_in_if.sink     height_in,
    hgm_out_if.source  moments_out
);
    import hgm_pkg::*;

    // column and row widths, plus one bit to hold the dimension itself
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;
    localparam int AW = CW + 1;
    localparam int RAM_DEPTH = 2 ** AW;

    // sequencer codes
    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_RD_ABOVE    = 4'd1;
    localparam logic [3:0] S_RD_LEFT     = 4'd2;
    localparam logic [3:0] S_RD_RIGHT    = 4'd3;
    localparam logic [3:0] S_SCALE_V     = 4'd4;
    localparam logic [3:0] S_SCALE_U     = 4'd5;
    localparam logic [3:0] S_SAT_U       = 4'd6;
    localparam logic [3:0] S_SQ_UU       = 4'd7;
    localparam logic [3:0] S_SQ_VV       = 4'd8;
    localparam logic [3:0] S_SQ_UV       = 4'd9;
    localparam logic [3:0] S_EMIT_PEND   = 4'd10;
    localparam logic [3:0] S_EMIT_BORDER = 4'd11;

    // configuration registers
    dim_cfg_t width_cfg_reg;
    dim_cfg_t height_cfg_reg;
    gain_t    gain_reg;

    // sequencer and counters
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // per-request context
    height_t       sample_reg;
    logic [CW-1:0] c_reg;
    logic          parity_reg;
    logic          has_above_reg;
    logic          interior_reg;
    logic          last_row_reg;
    logic          last_col_reg;

    // datapath
    height_t     above_reg;
    height_t     left_reg;
    diff_t       diff_u_reg;
    scale_prod_t prod_reg;
    slope_t      du_reg;
    slope_t      dv_reg;
    slope_uv_t   uu_reg;
    slope_uv_t   vv_reg;
    slope_uv_t   uv_reg;

    // output register
    logic      out_valid_reg;
    slope_t    out_u_reg;
    slope_t    out_v_reg;
    slope_sq_t out_uu_reg;
    slope_sq_t out_vv_reg;
    slope_uv_t out_uv_reg;
    logic      out_last_reg;

    // effective dimensions and saturated position
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] c_eff;
    logic [RW-1:0] r_eff;
    logic          acc_last_col;
    logic          acc_last_row;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // shared multipliers
    diff_t       diff_v;
    diff_t       diff_u;
    diff_t       scale_op;
    scale_prod_t scale_prod;
    slope_t      sq_a;
    slope_t      sq_b;
    slope_uv_t   sq_prod;

    logic accept;
    logic out_free;
    logic out_load_pend;
    logic out_load_border;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= IMAGE_WIDTH_RST;
            height_cfg_reg <= IMAGE_HEIGHT_RST;
            gain_reg       <= SCALE_GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg.data[10:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg.data[10:0];
                REG_SCALE_GAIN:   gain_reg       <= cfg.data;
                default:          ;
            endcase
        end
    end

    // clamp dimensions to the supported range
    always_comb
    begin
        if (width_cfg_reg < 11'(MIN_DIM))
            w_eff = WW'(MIN_DIM);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_cfg_reg);

        if (height_cfg_reg < 11'(MIN_DIM))
            h_eff = HW'(MIN_DIM);
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_cfg_reg);
    end

    // position of the accepted texel, saturated to the frame
    always_comb
    begin
        if ({1'b0, col_reg} >= w_eff - WW'(1))
            c_eff = CW'(w_eff - WW'(1));
        else
            c_eff = col_reg;

        if ({1'b0, row_reg} >= h_eff - HW'(1))
            r_eff = RW'(h_eff - HW'(1));
        else
            r_eff = row_reg;

        acc_last_col = ({1'b0, c_eff} == w_eff - WW'(1));
        acc_last_row = ({1'b0, r_eff} == h_eff - HW'(1));
    end

    assign height_in.ready = (state_reg == S_IDLE);
    assign accept          = height_in.valid && height_in.ready;
    assign out_free        = !out_valid_reg || moments_out.ready;

    // raster counters advance at acceptance
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (acc_last_col)
            begin
                col_next = '0;
                row_next = acc_last_row ? '0 : RW'(r_eff + RW'(1));
            end
            else
            begin
                col_next = CW'(c_eff + CW'(1));
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_load_pend   = 1'b0;
        out_load_border = 1'b0;
        unique case (state_reg)
            S_IDLE:        if (accept) state_next = S_RD_ABOVE;
            S_RD_ABOVE:    state_next = S_RD_LEFT;
            S_RD_LEFT:     state_next = S_RD_RIGHT;
            S_RD_RIGHT:    state_next = S_SCALE_V;
            S_SCALE_V:     state_next = S_SCALE_U;
            S_SCALE_U:     state_next = S_SAT_U;
            S_SAT_U:       state_next = S_SQ_UU;
            S_SQ_UU:       state_next = S_SQ_VV;
            S_SQ_VV:       state_next = S_SQ_UV;
            S_SQ_UV:       state_next = S_EMIT_PEND;
            S_EMIT_PEND:
            begin
                if (!has_above_reg)
                begin
                    state_next = last_row_reg ? S_EMIT_BORDER : S_IDLE;
                end
                else if (out_free)
                begin
                    out_load_pend = 1'b1;
                    state_next    = last_row_reg ? S_EMIT_BORDER : S_IDLE;
                end
            end
            S_EMIT_BORDER:
            begin
                if (out_free)
                begin
                    out_load_border = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // request context captured at acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg    <= height_in.height_sample;
            c_reg         <= c_eff;
            parity_reg    <= r_eff[0];
            has_above_reg <= (r_eff != '0);
            interior_reg  <= (r_eff >= RW'(2)) && (c_eff != '0) && !acc_last_col;
            last_row_reg  <= acc_last_row;
            last_col_reg  <= acc_last_col;
        end
    end

    // line buffer addressing: two rows above, then left and right of the row above
    always_comb
    begin
        unique case (state_reg)
            S_RD_LEFT:  ram_raddr = {~parity_reg, CW'(c_reg - CW'(1))};
            S_RD_RIGHT: ram_raddr = {~parity_reg, CW'(c_reg + CW'(1))};
            default:    ram_raddr = {parity_reg, c_reg};
        endcase
    end

    // own sample replaces the entry two rows up once that has been read
    assign ram_we    = (state_reg == S_RD_LEFT);
    assign ram_waddr = {parity_reg, c_reg};

    hgm_ram #(
        .WIDTH (16),
        .DEPTH (RAM_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // differences and shared scale multiplier
    assign diff_v     = diff_t'(sample_reg) - diff_t'(above_reg);
    assign diff_u     = diff_t'($signed(ram_rdata)) - diff_t'(left_reg);
    assign scale_op   = (state_reg == S_SCALE_V) ? diff_v : diff_u_reg;
    assign scale_prod = scale_prod_t'(scale_op) * scale_prod_t'($signed({1'b0, gain_reg}));

    // shared square multiplier
    always_comb
    begin
        unique case (state_reg)
            S_SQ_UU:
            begin
                sq_a = du_reg;
                sq_b = du_reg;
            end
            S_SQ_VV:
            begin
                sq_a = dv_reg;
                sq_b = dv_reg;
            end
            default:
            begin
                sq_a = du_reg;
                sq_b = dv_reg;
            end
        endcase
    end

    assign sq_prod = slope_uv_t'(sq_a) * slope_uv_t'(sq_b);

    // datapath registers stepped by the sequencer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD_LEFT)
            above_reg <= $signed(ram_rdata);
        if (state_reg == S_RD_RIGHT)
            left_reg <= $signed(ram_rdata);
        if (state_reg == S_SCALE_V)
            diff_u_reg <= diff_u;
        if (state_reg == S_SCALE_V || state_reg == S_SCALE_U)
            prod_reg <= scale_prod;
        if (state_reg == S_SCALE_U)
            dv_reg <= interior_reg ? scale_round_sat(prod_reg) : '0;
        if (state_reg == S_SAT_U)
            du_reg <= interior_reg ? scale_round_sat(prod_reg) : '0;
        if (state_reg == S_SQ_UU)
            uu_reg <= sq_prod;
        if (state_reg == S_SQ_VV)
            vv_reg <= sq_prod;
        if (state_reg == S_SQ_UV)
            uv_reg <= sq_prod;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_pend || out_load_border)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (moments_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_pend)
        begin
            out_u_reg    <= du_reg;
            out_v_reg    <= dv_reg;
            out_uu_reg   <= uu_reg[46:0];
            out_vv_reg   <= vv_reg[46:0];
            out_uv_reg   <= uv_reg;
            out_last_reg <= 1'b0;
        end
        else if (out_load_border)
        begin
            out_u_reg    <= '0;
            out_v_reg    <= '0;
            out_uu_reg   <= '0;
            out_vv_reg   <= '0;
            out_uv_reg   <= '0;
            out_last_reg <= last_col_reg;
        end
    end

    assign moments_out.valid      = out_valid_reg;
    assign moments_out.slope_u    = out_u_reg;
    assign moments_out.slope_v    = out_v_reg;
    assign moments_out.slope_u_sq = out_uu_reg;
    assign moments_out.slope_v_sq = out_vv_reg;
    assign moments_out.slope_uv   = out_uv_reg;
    assign moments_out.frame_last = out_last_reg;

    // the frame end marker only rides on a border result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_u_reg == '0 && out_v_reg == '0)
        else $error("frame_last on a non-border result");

    // the column counter stays inside the frame after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> {1'b0, col_reg} < $past(w_eff))
        else $error("column counter beyond image width");

    // a zero horizontal slope gives zero moments involving it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_u_reg == '0 |-> out_uu_reg == '0 && out_uv_reg == '0)
        else $error("moments inconsistent with zero slope_u");

endmodule
